@@ rtl/iobbl_pkg.sv @@
// Shared widths, codes and defaults for the I/O byte budget limiter.
`default_nettype none

package iobbl_pkg;

  localparam int RATE_W   = 40;
  localparam int COUNT_W  = 32;
  localparam int FUNC_W   = 3;
  localparam int DEC_W    = 3;
  localparam int S_DATA_W = 40;
  localparam int M_DATA_W = 40;
  localparam int CFG_IDX_W = 1;

  localparam int WINDOWS_PER_SECOND_DEF = 8;

  localparam logic [FUNC_W-1:0] FUNC_WRITE      = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ       = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_TICK       = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_SWITCH_ON  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_SWITCH_OFF = 3'd4;

  localparam logic [DEC_W-1:0] DEC_ADMITTED  = 3'd0;
  localparam logic [DEC_W-1:0] DEC_PASSED    = 3'd1;
  localparam logic [DEC_W-1:0] DEC_WAIT      = 3'd2;
  localparam logic [DEC_W-1:0] DEC_GAVE_UP   = 3'd3;
  localparam logic [DEC_W-1:0] DEC_EVENT     = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_WRITE_RATE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_READ_RATE  = 1'd1;

  typedef struct packed {
    logic [DEC_W-1:0]  decision;
    logic [RATE_W-1:0] budget_left;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/iobbl_div.sv @@
// Window budget unit: divides a per-second limit by a constant through a reciprocal multiply of four partial products.
`default_nettype none

module iobbl_div #(
  parameter int DIVISOR = iobbl_pkg::WINDOWS_PER_SECOND_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [iobbl_pkg::RATE_W-1:0] dividend,
  output logic                             busy,
  output logic [iobbl_pkg::RATE_W-1:0]     quotient
);

  localparam int RW    = iobbl_pkg::RATE_W;
  localparam int HalfW = RW / 2;
  localparam int RecW  = RW + 1;
  localparam int LogD  = $clog2(DIVISOR);
  localparam int Shift = RW + LogD;
  localparam int AccW  = Shift + RW;
  // The rounded-up reciprocal is exact for every dividend below 2**RW.
  localparam logic [63:0] Recip64 =
    ((64'd1 << Shift) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [RecW-1:0] Recip = Recip64[RecW-1:0];

  logic [RW-1:0]          x;
  logic [1:0]             step;
  logic [AccW-1:0]        acc;
  logic [HalfW-1:0]       x_part;
  logic [RecW-HalfW-1:0]  m_part;
  logic [RecW-1:0]        prod;
  logic [AccW-1:0]        prod_ext;
  logic [AccW-1:0]        acc_next;

  // One partial product per cycle: low by low, low by high, high by low, high by high.
  always_comb begin
    x_part   = step[1] ? x[RW-1:HalfW] : x[HalfW-1:0];
    m_part   = step[0] ? Recip[RecW-1:HalfW] : {1'b0, Recip[HalfW-1:0]};
    prod     = RecW'(x_part) * RecW'(m_part);
    prod_ext = AccW'(prod);
    case (step)
      2'd0:       acc_next = acc + prod_ext;
      2'd1, 2'd2: acc_next = acc + (prod_ext << HalfW);
      default:    acc_next = acc + (prod_ext << (2 * HalfW));
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      x    <= '0;
      step <= '0;
      acc  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      x    <= dividend;
      step <= '0;
      acc  <= '0;
    end else if (busy) begin
      acc  <= acc_next;
      step <= step + 2'd1;
      if (step == 2'd3) begin
        busy <= 1'b0;
      end
    end
  end

  assign quotient = acc[Shift +: RW];

endmodule

`default_nettype wire

@@ rtl/io_byte_budget_limiter.sv @@
// Top level of the fixed-window I/O byte budget limiter.
//
//   channel  direction  accepted when            payload
//   s_*      in         s_tvalid && s_tready     tuser: func; tdata: request fields
//   m_*      out        m_tvalid && m_tready     tuser: decision; tdata: budget_left
//   cfg_*    in         cfg_we                   index 0 write rate, 1 read rate
//
// One beat is accepted per cycle while s_tready is high; its result is registered into the output stage.
// A two-entry output stage keeps input flowing while one result waits to be taken.
// A nonzero limit write recomputes that window budget with a reciprocal
// multiply; s_tready is held low while the multiply runs.
// Reset clears the budgets, the used counters and the output stage.
`default_nettype none

module io_byte_budget_limiter #(
  parameter int WINDOWS_PER_SECOND = iobbl_pkg::WINDOWS_PER_SECOND_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // From bit 0: byte_count[31:0], exempt_class, signal_pending, in_page_fault, zero fill.
  input  wire logic [iobbl_pkg::S_DATA_W-1:0]   s_tdata,
  // From bit 0: func[2:0].
  input  wire logic [iobbl_pkg::FUNC_W-1:0]     s_tuser,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // From bit 0: budget_left[39:0].
  output logic [iobbl_pkg::M_DATA_W-1:0]        m_tdata,
  // From bit 0: decision[2:0].
  output logic [iobbl_pkg::DEC_W-1:0]           m_tuser,
  input  wire logic                             cfg_we,
  input  wire logic [iobbl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [iobbl_pkg::RATE_W-1:0]     cfg_data
);

  localparam int RW = iobbl_pkg::RATE_W;
  localparam int CW = iobbl_pkg::COUNT_W;

  logic          wr_start;
  logic          rd_start;
  logic          wr_busy;
  logic          rd_busy;
  logic [RW-1:0] wr_budget;
  logic [RW-1:0] rd_budget;

  always_comb begin
    wr_start = 1'b0;
    rd_start = 1'b0;
    if (cfg_we && cfg_data != '0) begin
      unique case (cfg_index)
        iobbl_pkg::REG_WRITE_RATE: wr_start = 1'b1;
        iobbl_pkg::REG_READ_RATE:  rd_start = 1'b1;
        default: ;
      endcase
    end
  end

  iobbl_div #(.DIVISOR(WINDOWS_PER_SECOND)) u_wr_div (
    .clk      (clk),
    .rst      (rst),
    .start    (wr_start),
    .dividend (cfg_data),
    .busy     (wr_busy),
    .quotient (wr_budget)
  );

  iobbl_div #(.DIVISOR(WINDOWS_PER_SECOND)) u_rd_div (
    .clk      (clk),
    .rst      (rst),
    .start    (rd_start),
    .dividend (cfg_data),
    .busy     (rd_busy),
    .quotient (rd_budget)
  );

  logic                          limiting_on;
  logic [RW-1:0]                 wr_used;
  logic [RW-1:0]                 rd_used;
  logic                          limiting_on_next;
  logic [RW-1:0]                 wr_used_next;
  logic [RW-1:0]                 rd_used_next;

  logic [iobbl_pkg::FUNC_W-1:0]  func;
  logic [CW-1:0]                 byte_count;
  logic                          exempt_class;
  logic                          signal_pending;
  logic                          in_page_fault;

  logic                          is_read;
  logic [RW-1:0]                 budget;
  logic [RW-1:0]                 used;
  logic [RW-1:0]                 rem;
  logic [RW-1:0]                 count_ext;
  logic                          fits;
  logic                          bypass;
  iobbl_pkg::result_t            res;

  logic                          accept;
  logic                          pop;
  logic                          main_valid;
  logic                          skid_valid;
  iobbl_pkg::result_t            main_res;
  iobbl_pkg::result_t            skid_res;

  assign func           = s_tuser;
  assign byte_count     = s_tdata[CW-1:0];
  assign exempt_class   = s_tdata[CW];
  assign signal_pending = s_tdata[CW+1];
  assign in_page_fault  = s_tdata[CW+2];

  always_comb begin
    is_read   = (func == iobbl_pkg::FUNC_READ);
    budget    = is_read ? rd_budget : wr_budget;
    used      = is_read ? rd_used : wr_used;
    rem       = (budget > used) ? budget - used : '0;
    count_ext = {{(RW - CW){1'b0}}, byte_count};
    fits      = rem >= count_ext;
    bypass    = !limiting_on || exempt_class || signal_pending;

    limiting_on_next     = limiting_on;
    wr_used_next         = wr_used;
    rd_used_next         = rd_used;
    res.decision         = iobbl_pkg::DEC_EVENT;
    res.budget_left      = '0;

    unique case (func) inside
      iobbl_pkg::FUNC_WRITE, iobbl_pkg::FUNC_READ: begin
        res.budget_left = rem;
        if (bypass) begin
          res.decision = iobbl_pkg::DEC_PASSED;
        end else if (fits) begin
          res.decision    = iobbl_pkg::DEC_ADMITTED;
          res.budget_left = rem - count_ext;
          if (is_read) begin
            rd_used_next = rd_used + count_ext;
          end else begin
            wr_used_next = wr_used + count_ext;
          end
        end else if (is_read && in_page_fault) begin
          res.decision = iobbl_pkg::DEC_GAVE_UP;
        end else begin
          res.decision = iobbl_pkg::DEC_WAIT;
        end
      end
      iobbl_pkg::FUNC_TICK: begin
        if (limiting_on) begin
          wr_used_next = '0;
          rd_used_next = '0;
        end
      end
      iobbl_pkg::FUNC_SWITCH_ON: begin
        limiting_on_next = 1'b1;
        wr_used_next     = wr_budget;
        rd_used_next     = rd_budget;
      end
      iobbl_pkg::FUNC_SWITCH_OFF: begin
        limiting_on_next = 1'b0;
      end
      default: ;
    endcase
  end

  assign s_tready = !wr_busy && !rd_busy && !skid_valid;
  assign accept   = s_tvalid && s_tready;
  assign pop      = main_valid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      limiting_on <= 1'b0;
      wr_used     <= '0;
      rd_used     <= '0;
    end else if (accept) begin
      limiting_on <= limiting_on_next;
      wr_used     <= wr_used_next;
      rd_used     <= rd_used_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        main_res   <= skid_res;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= accept;
        if (accept) begin
          main_res <= res;
        end
      end
    end else if (accept) begin
      if (!main_valid) begin
        main_res   <= res;
        main_valid <= 1'b1;
      end else begin
        skid_res   <= res;
        skid_valid <= 1'b1;
      end
    end
  end

  assign m_tvalid = main_valid;
  assign m_tuser  = main_res.decision;
  assign m_tdata  = main_res.budget_left;

endmodule

`default_nettype wire

@@ rtl/iobbl_checker.sv @@
// Port-level assertions for the I/O byte budget limiter and their bind.
`default_nettype none

module iobbl_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             s_tready,
  input wire logic                             m_tvalid,
  input wire logic                             m_tready,
  input wire logic [iobbl_pkg::M_DATA_W-1:0]   m_tdata,
  input wire logic [iobbl_pkg::DEC_W-1:0]      m_tuser,
  input wire logic                             cfg_we,
  input wire logic [iobbl_pkg::RATE_W-1:0]     cfg_data
);

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its contents.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  // The output stage comes out of reset empty.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result beat offered right after reset");

  // Events always report a zero budget.
  a_event_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == iobbl_pkg::DEC_EVENT |-> m_tdata == '0)
    else $error("event beat carries a nonzero budget");

  // A nonzero limit write starts the budget multiply, which holds off input.
  a_cfg_stall: assert property (@(posedge clk) disable iff (rst)
    !rst && cfg_we && cfg_data != '0 |=> !s_tready)
    else $error("input accepted while the budget is being recomputed");

endmodule

bind io_byte_budget_limiter iobbl_checker u_checker (.*);

`default_nettype wire
